### design/cpr_pkg.sv
// Package for the CAN packet reassembler: event codes, commands, sizes.
// No dependencies.
`timescale 1ns / 1ps
package cpr_pkg;
    localparam int PACKET_BYTES = 1024;
    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam int LEN_W = ADDR_W + 1;
    localparam int LANES = 7;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_SEGMENT  = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;
    localparam logic [1:0] EV_DROP     = 2'd3;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic CFG_ACCEPT_ID = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // One byte write request produced by a lane.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;
endpackage

### design/cpr_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/cpr_lane.sv
// One payload lane: decides whether its frame byte is written and where.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
module cpr_lane import cpr_pkg::*; (
    input  logic [2:0]       i_slot,
    input  logic [2:0]       i_count,
    input  logic [LEN_W-1:0] i_base,
    input  logic [7:0]       i_byte,
    output t_wr              o_wr
);
    logic [LEN_W-1:0] w_pos;
    always_comb begin
        w_pos = i_base + LEN_W'(i_slot);
        o_wr.en = (i_slot < i_count) && (w_pos < LEN_W'(PACKET_BYTES));
        o_wr.addr = w_pos[ADDR_W-1:0];
        o_wr.data = i_byte;
    end
endmodule

### design/can_packet_reassembler_top.sv
// Top level of the CAN packet reassembler: control, lanes, write queue, RAM.
// Depends on cpr_pkg, cpr_lane, cpr_ram.
//
// Channel  Direction  Handshake
// in       input      i_valid / o_stall
// out      output     o_valid / i_stall
// cfg      input      i_cfg_valid / o_cfg_ready
//
// A frame is decided when accepted; its up to seven byte writes then drain
// into the byte-wide RAM one per cycle. A read waits on the registered RAM read.
// Reset is synchronous, active low, and needs no clearing pass. The output
// register holds one result and the block stalls input while that result
// waits, a read is pending or writes are pending.
`timescale 1ns / 1ps
module can_packet_reassembler_top import cpr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_cmd,
    input  logic [28:0]  i_frame_id,
    input  logic         i_frame_ext,
    input  logic [3:0]   i_frame_dlc,
    input  logic [63:0]  i_frame_data,
    input  logic [9:0]   i_read_index,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [1:0]   o_event_code,
    output logic [10:0]  o_packet_length,
    output logic [31:0]  o_drop_total,
    output logic [7:0]   o_read_byte,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    logic [10:0]      r_accept_id;
    logic [15:0]      r_timeout;
    logic [LEN_W-1:0] r_exp, n_exp;
    logic [LEN_W-1:0] r_rcv, n_rcv;
    logic [3:0]       r_seq, n_seq;
    logic [15:0]      r_ticks, n_ticks;
    logic [31:0]      r_drops, n_drops;
    t_wr              r_q [LANES];
    t_wr              w_wr [LANES];
    logic             r_rd_pend;
    logic             r_rd_oor;
    logic [1:0]       n_ev;
    logic [LEN_W-1:0] n_len;
    logic             w_acc, w_out_free, w_q_busy, w_do_wr;
    logic [2:0]       w_cnt;
    logic [LEN_W-1:0] w_base;
    logic [7:0]       w_b0;
    logic             w_start, w_end;
    logic [LEN_W-1:0] w_room;
    logic [15:0]      w_decl;
    logic [3:0]       w_avail;
    logic [7:0]       w_rdata;
    t_wr              w_head;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_id <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ACCEPT_ID) r_accept_id <= i_cfg_data[10:0];
            else r_timeout <= i_cfg_data;
        end
    end

    always_comb begin
        w_q_busy = 1'b0;
        for (int k = 0; k < LANES; k++) w_q_busy = w_q_busy | r_q[k].en;
    end
    assign w_out_free = !o_valid || !i_stall;
    assign o_stall = w_q_busy || r_rd_pend || !w_out_free;
    assign w_acc = i_valid && !o_stall;

    assign w_b0 = i_frame_data[7:0];
    assign w_start = w_b0[7];
    assign w_end = w_b0[6];
    assign w_decl = i_frame_data[23:8];
    assign w_room = r_exp - r_rcv;

    always_comb begin
        n_exp = r_exp; n_rcv = r_rcv; n_seq = r_seq; n_ticks = r_ticks;
        n_drops = r_drops; n_ev = EV_NONE; n_len = '0; w_cnt = '0;
        w_base = '0; w_do_wr = 1'b0; w_avail = '0;
        if (i_cmd == CMD_FRAME) begin
            if (i_frame_id == {18'd0, r_accept_id} && !i_frame_ext &&
                i_frame_dlc != 4'd0 && i_frame_dlc <= 4'd8) begin
                n_ev = EV_SEGMENT;
                if (w_start) begin
                    if (r_exp != '0) begin n_drops = n_drops + 32'd1; n_ev = EV_DROP; end
                    if (i_frame_dlc < 4'd3) begin
                        n_drops = n_drops + 32'd1; n_ev = EV_DROP;
                    end else if (w_decl == 16'd0 || w_decl > 16'(PACKET_BYTES)) begin
                        n_exp = '0; n_drops = n_drops + 32'd1; n_ev = EV_DROP;
                    end else begin
                        n_exp = w_decl[LEN_W-1:0];
                        w_avail = i_frame_dlc - 4'd3;
                        w_cnt = (LEN_W'(w_avail) > n_exp) ? n_exp[2:0] : w_avail[2:0];
                        n_rcv = LEN_W'(w_cnt);
                        w_do_wr = 1'b1;
                    end
                end else if (r_exp == '0 || w_b0[3:0] != r_seq) begin
                    n_drops = n_drops + 32'd1; n_exp = '0; n_ev = EV_DROP;
                end else begin
                    w_avail = i_frame_dlc - 4'd1;
                    w_cnt = (LEN_W'(w_avail) > w_room) ? w_room[2:0] : w_avail[2:0];
                    w_base = r_rcv;
                    n_rcv = r_rcv + LEN_W'(w_cnt);
                    w_do_wr = 1'b1;
                end
                if (w_do_wr) begin
                    n_seq = w_b0[3:0] + 4'd1;
                    n_ticks = '0;
                    if (w_end != (n_rcv == n_exp)) begin
                        n_exp = '0; n_drops = n_drops + 32'd1; n_ev = EV_DROP;
                    end else if (w_end) begin
                        n_len = n_exp; n_exp = '0; n_ev = EV_COMPLETE;
                    end
                end
            end
        end else if (i_cmd == CMD_TICK) begin
            if (r_ticks != 16'hFFFF) n_ticks = r_ticks + 16'd1;
            if (r_exp != '0 && n_ticks > r_timeout) begin
                n_exp = '0; n_drops = r_drops + 32'd1; n_ev = EV_DROP;
            end
        end
    end

    // Start frames place payload from byte 3, later frames from byte 1.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [7:0] w_byte;
        assign w_byte = (i_cmd == CMD_FRAME && w_start) ?
            ((g + 3 < 8) ? i_frame_data[((g + 3) % 8)*8 +: 8] : 8'd0) :
            i_frame_data[(g + 1)*8 +: 8];
        cpr_lane u_lane (
            .i_slot  (3'(g)),
            .i_count (w_do_wr ? w_cnt : 3'd0),
            .i_base  (w_base),
            .i_byte  (w_byte),
            .o_wr    (w_wr[g])
        );
    end

    // Merge stage: the lanes' requests queue up and drain one per cycle.
    always_comb begin
        w_head = '0;
        for (int k = LANES - 1; k >= 0; k--) if (r_q[k].en) w_head = r_q[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) r_q[k].en <= 1'b0;
        end else if (w_acc) begin
            for (int k = 0; k < LANES; k++) r_q[k] <= w_wr[k];
        end else begin
            for (int k = 0; k < LANES; k++) begin
                if (r_q[k].en && r_q[k].addr == w_head.addr) r_q[k].en <= 1'b0;
            end
        end
    end

    cpr_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_head.en),
        .i_waddr (w_head.addr),
        .i_wdata (w_head.data),
        .i_raddr (i_read_index[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0; r_rcv <= '0; r_seq <= '0; r_ticks <= '0; r_drops <= '0;
            o_valid <= 1'b0; r_rd_pend <= 1'b0;
        end else begin
            if (r_rd_pend) begin
                r_rd_pend <= 1'b0;
                o_valid <= 1'b1;
                o_read_byte <= r_rd_oor ? 8'd0 : w_rdata;
            end else if (w_acc) begin
                r_exp <= n_exp; r_rcv <= n_rcv; r_seq <= n_seq;
                r_ticks <= n_ticks; r_drops <= n_drops;
                o_event_code <= n_ev;
                o_packet_length <= n_len;
                o_drop_total <= n_drops;
                o_read_byte <= 8'd0;
                r_rd_oor <= 32'(i_read_index) >= PACKET_BYTES;
                if (i_cmd == CMD_READ) begin
                    r_rd_pend <= 1'b1;
                    o_valid <= 1'b0;
                end else begin
                    o_valid <= 1'b1;
                end
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_busy || r_rd_pend) |-> !w_acc) else $error("accept while busy");
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> o_valid) else $error("read result lost");
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp <= LEN_W'(PACKET_BYTES)) else $error("length out of range");
    a_rcv_le_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != '0) |-> (r_rcv <= r_exp)) else $error("count past length");
endmodule
